// File: sv/extent_map_block_translator_core_macros.svh
// assertion macros for the extent map translator checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef EXTENT_MAP_BLOCK_TRANSLATOR_CORE_MACROS_SVH
`define EXTENT_MAP_BLOCK_TRANSLATOR_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define EMBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define EMBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/embt_pkg.sv
// shared types, codes and sizing functions for the extent map translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package embt_pkg;

    localparam int BLOCK_W         = 32;
    localparam int LOGICAL_W       = BLOCK_W + 8;
    localparam int PHYS_W          = BLOCK_W + 1;
    localparam int OUT_USED_W      = 9;
    localparam int DEF_MAX_EXTENTS = 256;
    localparam int TREE_RADIX      = 8;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_FIND  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_ZERO      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } t_state;

    typedef struct packed {
        logic [1:0]           action;
        logic [BLOCK_W-1:0]   start_block;
        logic [BLOCK_W-1:0]   block_count;
        logic [LOGICAL_W-1:0] lookup_block;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]            status;
        logic [PHYS_W-1:0]     physical_block;
        logic [BLOCK_W-1:0]    run_length;
        logic [OUT_USED_W-1:0] entries_used;
    } t_out_beat;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 add_en;
        logic [BLOCK_W-1:0]   start_block;
        logic [BLOCK_W-1:0]   block_count;
        logic [LOGICAL_W-1:0] lookup_block;
    } t_cell_cmd;

    // what a cell hands to its right-hand neighbor
    typedef struct packed {
        logic [BLOCK_W-1:0]   start;
        logic [BLOCK_W-1:0]   len;
        logic [LOGICAL_W-1:0] logical;
        logic                 lt;
    } t_link;

    typedef struct packed {
        logic               hit;
        logic [PHYS_W-1:0]  phys;
        logic [BLOCK_W-1:0] run;
    } t_hit;

    // entries left at reduction level k of the hit tree
    function automatic int level_count(input int n, input int k);
        int c;
        c = n;
        for (int s = 0; s < 16; s++) begin
            if (s < k) begin
                c = (c + TREE_RADIX - 1) / TREE_RADIX;
            end
        end
        return c;
    endfunction

    // register levels of the hit tree, leaf level included
    function automatic int tree_levels(input int n);
        int c;
        int lv;
        c  = n;
        lv = 1;
        for (int s = 0; s < 16; s++) begin
            if (c > 1) begin
                c  = (c + TREE_RADIX - 1) / TREE_RADIX;
                lv = lv + 1;
            end
        end
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: sv/embt_cell.sv
// one table slot of the extent chain: holds an extent and its logical start
// depends on embt_pkg
`timescale 1ns / 1ps
`default_nettype none

module embt_cell
    import embt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_active,
    input  wire t_link     i_prev,
    output t_link          o_link,
    output t_hit           o_hit
);

    logic [BLOCK_W-1:0]   r_start, n_start;
    logic [BLOCK_W-1:0]   r_len, n_len;
    logic [LOGICAL_W-1:0] r_logical, n_logical;
    logic [LOGICAL_W:0]   r_diff, n_diff;
    logic                 w_lt;
    logic                 w_within;
    logic [BLOCK_W-1:0]   w_off;

    assign w_lt = i_active && (r_start < i_cmd.start_block);

    // insert: keep, take the new extent, or shift in from the left
    always_comb begin
        n_start   = r_start;
        n_len     = r_len;
        n_logical = r_logical;
        if (i_cmd.add_en && !w_lt) begin
            if (i_prev.lt) begin
                n_start   = i_cmd.start_block;
                n_len     = i_cmd.block_count;
                n_logical = i_prev.logical + LOGICAL_W'(i_prev.len);
            end else begin
                n_start   = i_prev.start;
                n_len     = i_prev.len;
                n_logical = i_prev.logical + LOGICAL_W'(i_cmd.block_count);
            end
        end
    end

    // borrow bit set means the block lies ahead of this extent
    assign n_diff = {1'b0, i_cmd.lookup_block} - {1'b0, r_logical};

    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_len     <= n_len;
        r_logical <= n_logical;
        r_diff    <= n_diff;
    end

    assign w_within = !r_diff[LOGICAL_W] && (r_diff[LOGICAL_W-1:0] < LOGICAL_W'(r_len));
    assign w_off    = r_diff[BLOCK_W-1:0];

    assign o_hit.hit  = i_active && w_within;
    assign o_hit.phys = PHYS_W'(r_start) + PHYS_W'(w_off);
    assign o_hit.run  = r_len - w_off;

    assign o_link.start   = r_start;
    assign o_link.len     = r_len;
    assign o_link.logical = r_logical;
    assign o_link.lt      = w_lt;

endmodule

`default_nettype wire

// File: sv/embt_hit_tree.sv
// registered priority tree that picks the first hit among all cells
// depends on embt_pkg
`timescale 1ns / 1ps
`default_nettype none

module embt_hit_tree
    import embt_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  wire logic i_clk,
    input  wire t_hit i_leaf [MAX_EXTENTS],
    output t_hit      o_root
);

    localparam int LV = tree_levels(MAX_EXTENTS);

    t_hit r_lvl [LV][MAX_EXTENTS];

    for (genvar gk = 0; gk < LV; gk++) begin : g_level
        for (genvar gj = 0; gj < MAX_EXTENTS; gj++) begin : g_node
            if (gk == 0) begin : g_leaf
                always_ff @(posedge i_clk) begin
                    r_lvl[0][gj] <= i_leaf[gj];
                end
            end else if (gj < level_count(MAX_EXTENTS, gk)) begin : g_pick
                t_hit n_pick;
                // lowest index wins: scan from the top down
                always_comb begin
                    int idx;
                    n_pick = '0;
                    for (int m = TREE_RADIX - 1; m >= 0; m--) begin
                        idx = gj * TREE_RADIX + m;
                        if (idx < level_count(MAX_EXTENTS, gk - 1)) begin
                            if (r_lvl[gk-1][idx].hit) begin
                                n_pick = r_lvl[gk-1][idx];
                            end
                        end
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_lvl[gk][gj] <= n_pick;
                end
            end else begin : g_unused
                always_ff @(posedge i_clk) begin
                    r_lvl[gk][gj] <= '0;
                end
            end
        end
    end

    assign o_root = r_lvl[LV-1][0];

endmodule

`default_nettype wire

// File: sv/extent_map_block_translator_core.sv
// Extent map block translator. A sorted table of extents (physical start,
// block count, running logical start) lives in a chain of MAX_EXTENTS cells,
// one extent per cell, cell 0 first. An add compares the new start in every
// cell at once; cells with a smaller start keep their extent, the first other
// cell takes the new one and the rest shift one place right, each fixing its
// own logical start from its left neighbor in the same cycle. A find
// subtracts every cell's logical start from the logical block in parallel,
// then a registered radix-8 tree picks the first matching cell. One item is
// worked at a time, and a new beat is taken only in the idle state. Add,
// clear and the unused action write their result in the execute state once
// the result register is free; a find moves on from the execute state, where
// the cells register their offsets, to the find state, which waits while the
// L = 1 + ceil(log8(MAX_EXTENTS)) register levels of the hit tree fill. A
// result that is not yet taken does not stop the next beat from being
// accepted; it only holds back the next result. Table entries are not
// cleared at reset; only entries below the fill count are ever looked at.

// top level: sequencer, fill count, cell chain, hit tree and output register
// depends on embt_pkg, embt_cell, embt_hit_tree
`timescale 1ns / 1ps
`default_nettype none

module extent_map_block_translator_core
    import embt_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_beat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_beat
);

    localparam int USED_W = $clog2(MAX_EXTENTS + 1);
    localparam int LV     = tree_levels(MAX_EXTENTS);
    localparam int CNT_W  = $clog2(LV + 1);

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [USED_W-1:0]   r_used, n_used;
    logic                r_out_valid, n_out_valid;

    // payload
    t_in_beat            r_item;
    t_out_beat           r_out, n_out;

    logic                w_in_fire;
    logic                w_slot_free;
    logic                w_full;
    t_cell_cmd           w_cmd;
    t_link               w_head;
    t_link               w_link [MAX_EXTENTS];
    t_hit                w_hit  [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] w_active;
    t_hit                w_root;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    // result register can take a new beat this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_full      = (r_used == USED_W'(MAX_EXTENTS));

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= i_in_beat;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // sequencer: one item from accept to result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_used      = r_used;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_cmd.add_en       = 1'b0;
        w_cmd.start_block  = r_item.start_block;
        w_cmd.block_count  = r_item.block_count;
        w_cmd.lookup_block = r_item.lookup_block;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.action == ACT_FIND) begin
                    // cells latch their offsets this cycle, tree follows
                    n_state = S_FIND;
                    n_cnt   = CNT_W'(LV);
                end else if (w_slot_free) begin
                    n_out.status         = STAT_OK;
                    n_out.physical_block = '0;
                    n_out.run_length     = '0;
                    if (r_item.action == ACT_ADD) begin
                        if (r_item.block_count == '0) begin
                            n_out.status = STAT_ZERO;
                        end else if (w_full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            w_cmd.add_en = 1'b1;
                            n_used       = r_used + USED_W'(1);
                        end
                    end else if (r_item.action == ACT_CLEAR) begin
                        n_used = '0;
                    end
                    n_out.entries_used = OUT_USED_W'(n_used);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (w_slot_free) begin
                    if (w_root.hit) begin
                        n_out.status         = STAT_OK;
                        n_out.physical_block = w_root.phys;
                        n_out.run_length     = w_root.run;
                    end else begin
                        n_out.status         = STAT_NOT_FOUND;
                        n_out.physical_block = '0;
                        n_out.run_length     = '0;
                    end
                    n_out.entries_used = OUT_USED_W'(r_used);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // left edge of the chain: an empty extent that always sorts first
    assign w_head.start   = '0;
    assign w_head.len     = '0;
    assign w_head.logical = '0;
    assign w_head.lt      = 1'b1;

    for (genvar gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
        // a cell holds a live extent when it sits below the fill count
        assign w_active[gi] = (USED_W'(gi) < r_used);

        if (gi == 0) begin : g_first
            embt_cell u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_active (w_active[gi]),
                .i_prev   (w_head),
                .o_link   (w_link[gi]),
                .o_hit    (w_hit[gi])
            );
        end else begin : g_rest
            embt_cell u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_active (w_active[gi]),
                .i_prev   (w_link[gi-1]),
                .o_link   (w_link[gi]),
                .o_hit    (w_hit[gi])
            );
        end
    end

    embt_hit_tree #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_hit_tree (
        .i_clk  (i_clk),
        .i_leaf (w_hit),
        .o_root (w_root)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

// File: sv/embt_checker.sv
// port-level checks for the extent map translator, bound to the top level
// depends on embt_pkg and extent_map_block_translator_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "extent_map_block_translator_core_macros.svh"

module embt_checker
    import embt_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out_beat
);

    `EMBT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid,
                      "result beat dropped before taken")
    `EMBT_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready,
                      "second beat accepted while busy")
    `EMBT_ASSERT_SAME(a_full_count, o_out_valid && (o_out_beat.status == STAT_FULL),
                      o_out_beat.entries_used == OUT_USED_W'(MAX_EXTENTS),
                      "full status with a partial table")
    `EMBT_ASSERT_SAME(a_miss_zero, o_out_valid && (o_out_beat.status == STAT_NOT_FOUND),
                      (o_out_beat.physical_block == '0) && (o_out_beat.run_length == '0),
                      "miss carries nonzero block or run")

endmodule

bind extent_map_block_translator_core embt_checker #(
    .MAX_EXTENTS (MAX_EXTENTS)
) u_embt_checker (.*);

`default_nettype wire

// File: tb/tb_extent_map_block_translator_core.sv
// testbench for extent_map_block_translator_core: queued stimulus, a clocked driver and
// monitor, and a behavioral extent table that predicts every result beat
// depends on embt_pkg and the core with its cell chain and hit tree
`timescale 1ns / 1ps

module tb_extent_map_block_translator_core;
    import embt_pkg::*;

    localparam int          TABLE_DEPTH  = DEF_MAX_EXTENTS;
    localparam int          STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int          TAIL_CYCLES  = 20;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          CALM_ITEMS   = 150;   // last stretch runs with no idling
    localparam int          PRINT_CAP    = 200;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;  // no operation behind this code

    // clock, reset and dut ports
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    extent_map_block_translator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_beat (out_beat)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // items waiting to be driven; hold_for_drain makes the driver wait until every
    // result already owed has come back before offering that item
    typedef struct {
        t_in_beat beat;
        bit       hold_for_drain;
    } t_pending;

    t_pending  pending_items[$];
    t_out_beat expected_results[$];
    int        mismatch_count = 0;

    // shadow extent table, updated as each beat is accepted
    logic [BLOCK_W-1:0]   map_phys   [TABLE_DEPTH];
    logic [BLOCK_W-1:0]   map_len    [TABLE_DEPTH];
    logic [LOGICAL_W-1:0] map_lstart [TABLE_DEPTH];
    int                   map_used = 0;

    // what the stimulus generator believes the table holds, so finds can aim
    // inside the mapped logical range
    int                   plan_used  = 0;
    logic [63:0]          plan_total = '0;

    // driver and monitor state
    logic in_fire = 1'b0;
    int   in_hold = 0;
    int   out_hold = 0;
    int   idle_level = 1;
    int   sent_items = 0;
    int   quiet_cycles = 0;

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    function automatic t_out_beat translate_beat(t_in_beat b);
        t_out_beat            r;
        int                   pos;
        bit                   hit;
        logic [LOGICAL_W-1:0] acc;
        logic [LOGICAL_W-1:0] off;
        r = '0;
        case (b.action)
            ACT_ADD: begin
                // zero count wins over a full table
                if (b.block_count == '0) begin
                    r.status = STAT_ZERO;
                end else if (map_used >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // slot just after the last smaller start, so equal starts
                    // get pushed behind the new extent
                    pos = 0;
                    hit = 1'b0;
                    for (int i = map_used; i > 0; i--) begin
                        if (!hit && map_phys[i-1] < b.start_block) begin
                            pos = i;
                            hit = 1'b1;
                        end
                    end
                    for (int i = map_used; i > pos; i--) begin
                        map_phys[i] = map_phys[i-1];
                        map_len[i]  = map_len[i-1];
                    end
                    map_phys[pos] = b.start_block;
                    map_len[pos]  = b.block_count;
                    map_used++;
                    // logical starts are rebuilt from the head, head insertion too
                    acc = '0;
                    for (int i = 0; i < map_used; i++) begin
                        map_lstart[i] = acc;
                        acc = acc + LOGICAL_W'(map_len[i]);
                    end
                    r.status = STAT_OK;
                end
            end
            ACT_FIND: begin
                r.status = STAT_NOT_FOUND;
                hit = 1'b0;
                for (int i = 0; i < map_used; i++) begin
                    if (!hit && b.lookup_block >= map_lstart[i]) begin
                        off = b.lookup_block - map_lstart[i];
                        if (off < {8'h00, map_len[i]}) begin
                            hit              = 1'b1;
                            r.status         = STAT_OK;
                            // start plus offset may carry into bit 32
                            r.physical_block = {1'b0, map_phys[i]} + off[BLOCK_W:0];
                            r.run_length     = map_len[i] - off[BLOCK_W-1:0];
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                map_used = 0;
            end
            default: begin
                // unused action: table untouched, ok status, zero payload
            end
        endcase
        r.entries_used = map_used[OUT_USED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        end
        mismatch_count++;
    endtask

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------

    task automatic queue_beat(logic [1:0] act, logic [BLOCK_W-1:0] start,
                              logic [BLOCK_W-1:0] count, logic [LOGICAL_W-1:0] lblock,
                              bit drain);
        t_pending p;
        p.beat.action       = act;
        p.beat.start_block  = start;
        p.beat.block_count  = count;
        p.beat.lookup_block = lblock;
        p.hold_for_drain    = drain;
        pending_items.push_back(p);
        // keep the planner's view of the table in step
        if (act == ACT_ADD && count != '0 && plan_used < TABLE_DEPTH) begin
            plan_used++;
            plan_total = plan_total + 64'(count);
        end else if (act == ACT_CLEAR) begin
            plan_used  = 0;
            plan_total = '0;
        end
    endtask

    function automatic logic [LOGICAL_W-1:0] any_lblock();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[LOGICAL_W-1:0];
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_start();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 31);          // crowd to force equal starts
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_count();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 4096);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // logical block mostly inside the mapped range, sometimes at or past its end
    function automatic logic [LOGICAL_W-1:0] pick_lblock();
        logic [63:0] w;
        if (plan_total == '0) begin
            return ($urandom_range(0, 1) == 0) ? '0 : any_lblock();
        end
        case ($urandom_range(0, 9))
            7:       return LOGICAL_W'(plan_total - 64'd1);
            8:       return plan_total[LOGICAL_W-1:0];
            9:       return any_lblock();
            default: begin
                w = {$urandom, $urandom};
                return LOGICAL_W'(w % plan_total);
            end
        endcase
    endfunction

    task automatic queue_find(bit drain);
        queue_beat(ACT_FIND, $urandom, $urandom, pick_lblock(), drain);
    endtask

    // clear, add until the table is full, then knock on the full table
    task automatic queue_fill_pass();
        queue_beat(ACT_CLEAR, $urandom, $urandom, any_lblock(), 1'b1);
        while (plan_used < TABLE_DEPTH) begin
            queue_beat(ACT_ADD, pick_start(),
                       ($urandom_range(0, 7) == 0) ? pick_count() : $urandom_range(1, 8),
                       any_lblock(), 1'b0);
        end
        queue_beat(ACT_ADD, pick_start(), '0, any_lblock(), 1'b0);   // zero on full table
        queue_beat(ACT_ADD, pick_start(), pick_count() | 32'd1, any_lblock(), 1'b0);
        repeat (12) queue_find(1'b0);
        queue_beat(ACT_ADD, 32'h0, 32'hFFFF_FFFF, any_lblock(), 1'b0);
        queue_find(1'b0);
    endtask

    // -------------------------------------------------------------------------
    // driver: new input beats at the falling edge
    // -------------------------------------------------------------------------

    // random idle decision; idle_level varies so some stretches never stall
    function automatic bit take_gap();
        if (pending_items.size() < CALM_ITEMS || idle_level == 0) begin
            return 1'b0;
        end
        if (idle_level == 1) begin
            return $urandom_range(0, 7) == 0;
        end
        return $urandom_range(0, 2) == 0;
    endfunction

    always @(negedge i_clk) begin : drive_beats
        logic     next_valid;
        t_in_beat next_beat;
        t_pending p;
        next_valid = in_valid;
        next_beat  = in_beat;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!in_valid || in_fire) begin
            next_valid = 1'b0;
            if (in_hold > 0) begin
                in_hold--;
            end else if (pending_items.size() != 0) begin
                if (pending_items[0].hold_for_drain && expected_results.size() != 0) begin
                    // hold back until every owed result has come out
                end else if (take_gap()) begin
                    in_hold = $urandom_range(0, 2);
                end else begin
                    p          = pending_items.pop_front();
                    next_valid = 1'b1;
                    next_beat  = p.beat;
                    sent_items++;
                    if (sent_items % 100 == 0) begin
                        idle_level = $urandom_range(0, 2);
                    end
                end
            end
        end
        in_valid <= next_valid;
        in_beat  <= next_beat;

        // result side back-pressure, same burst shape
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            out_ready <= 1'b0;
        end else if (take_gap()) begin
            out_hold = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // -------------------------------------------------------------------------
    // monitor: accepted beats sampled at the rising edge
    // -------------------------------------------------------------------------

    always @(posedge i_clk) begin : watch_beats
        t_out_beat want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing owed",
                                    64'(out_beat.physical_block), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_beat.status != want.status) begin
                        report_mismatch("status", 64'(out_beat.status), 64'(want.status));
                    end
                    if (out_beat.physical_block != want.physical_block) begin
                        report_mismatch("physical_block", 64'(out_beat.physical_block),
                                        64'(want.physical_block));
                    end
                    if (out_beat.run_length != want.run_length) begin
                        report_mismatch("run_length", 64'(out_beat.run_length),
                                        64'(want.run_length));
                    end
                    if (out_beat.entries_used != want.entries_used) begin
                        report_mismatch("entries_used", 64'(out_beat.entries_used),
                                        64'(want.entries_used));
                    end
                end
            end
            if (in_valid && in_ready) begin
                expected_results.push_back(translate_beat(in_beat));
            end
            // watchdog on total lack of progress
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // stimulus program and end of run
    // -------------------------------------------------------------------------

    initial begin : run_program
        logic [63:0] w;
        int          n_ops;
        bit          fill_done;

        // directed: empty table, unused action, zero count, equal starts,
        // head insertion, carry into bit 32 of the physical block, misses
        queue_beat(ACT_FIND, '0, '0, '0, 1'b0);
        queue_beat(ACT_UNUSED, '1, '1, '1, 1'b0);
        queue_beat(ACT_ADD, 32'hFFFF_FFFF, '0, '0, 1'b0);
        queue_beat(ACT_ADD, 32'd100, 32'd50, '0, 1'b0);
        queue_beat(ACT_ADD, 32'd100, 32'd7, '0, 1'b0);
        queue_beat(ACT_ADD, 32'd50, 32'd3, '0, 1'b0);
        queue_beat(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
        queue_beat(ACT_ADD, 32'd0, 32'd1, '0, 1'b0);
        queue_beat(ACT_ADD, 32'd0, 32'd9, '0, 1'b0);
        queue_beat(ACT_FIND, '0, '0, '0, 1'b0);
        queue_beat(ACT_FIND, '0, '0, 40'd9, 1'b0);
        queue_beat(ACT_FIND, '0, '0, 40'd25, 1'b0);
        queue_beat(ACT_FIND, '0, '0, LOGICAL_W'(plan_total - 64'd1), 1'b0);
        queue_beat(ACT_FIND, '0, '0, plan_total[LOGICAL_W-1:0], 1'b0);
        queue_beat(ACT_FIND, '1, '1, '1, 1'b0);
        queue_beat(ACT_FIND, '0, '0, LOGICAL_W'(plan_total - 64'h8000_0000), 1'b0);
        queue_beat(ACT_UNUSED, '0, '0, '0, 1'b0);
        queue_beat(ACT_FIND, '0, '0, 40'd70, 1'b0);
        queue_beat(ACT_CLEAR, '0, '0, '0, 1'b0);
        queue_beat(ACT_FIND, '0, '0, '0, 1'b0);
        queue_beat(ACT_ADD, '0, 32'hFFFF_FFFF, '0, 1'b0);
        queue_beat(ACT_FIND, '0, '0, 40'hFFFF_FFFE, 1'b0);
        queue_beat(ACT_CLEAR, '1, '1, '1, 1'b0);

        // random: mostly build-and-look sequences, two full-table passes, some noise
        queue_fill_pass();
        fill_done = 1'b0;
        while (pending_items.size() < RANDOM_ITEMS) begin
            if (!fill_done && pending_items.size() > 700) begin
                queue_fill_pass();
                fill_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                8, 9: begin
                    repeat (4) begin
                        w = {$urandom, $urandom};
                        queue_beat(w[1:0], $urandom, $urandom, any_lblock(), 1'b0);
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        queue_beat(ACT_CLEAR, $urandom, $urandom, any_lblock(),
                                   $urandom_range(0, 9) == 0);
                    end
                    n_ops = $urandom_range(3, 20);
                    repeat (n_ops) begin
                        if ($urandom_range(0, 1) == 0) begin
                            queue_beat(ACT_ADD, pick_start(), pick_count(), any_lblock(),
                                       1'b0);
                        end else begin
                            queue_find(1'b0);
                        end
                    end
                end
            endcase
        end

        // reset released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all beats to go in and every owed result to come out
        while (pending_items.size() != 0 || in_valid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
